// ----- sv/i2rs_pkg.sv -----
package i2rs_pkg;

  // Width of the signed value taken on the input channel.
  localparam int VALUE_BITS = 32;
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

  // One digit value; also the width of the radix register.
  localparam int DIG_W   = 6;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;

  // Index into the digit store and a count that can also hold its depth.
  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [DIG_W-1:0]   GLYPH_MAX   = DIG_W'(35);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // APB register map: one register per 32-bit word.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIG_W-1:0]      remainder;
  } div_rsp_t;

  function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
    radix_ok = r inside {[RADIX_MIN:RADIX_MAX]};
  endfunction

  // Digit value to lower-case ASCII; out-of-range values clamp to 'z'.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] c;
    c = (d > GLYPH_MAX) ? GLYPH_MAX : d;
    if (c < DIG_W'(10)) begin
      glyph = CHAR_ZERO + CHAR_W'(c);
    end else begin
      glyph = CHAR_ALPHA + CHAR_W'(c) - CHAR_W'(10);
    end
  endfunction

endpackage

// ----- sv/i2rs_divider.sv -----
module i2rs_divider
  import i2rs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIG_W-1:0]      rem_r, rem_nxt;
  logic [RADIX_W-1:0]    dvs_r, dvs_nxt;

  logic [DIG_W:0] rem_sh;
  logic           fits;

  // Restoring division, one quotient bit per cycle. The dividend sits in the
  // quotient register and shifts out at the top as quotient bits enter below.
  always_comb begin
    rem_sh   = {rem_r, quo_r[VALUE_BITS-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIG_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIG_W-1:0];
      quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
      cnt_nxt = cnt_r + IDX_W'(1);
      if (cnt_r == IDX_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- sv/i2rs_seq.sv -----
module i2rs_seq
  import i2rs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  out_last,
  output logic                  out_bad,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              neg_r, neg_nxt;
  logic              bad_r, bad_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [DIG_W-1:0]  digit_store [VALUE_BITS];
  logic              store_we;

  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] oc_r, oc_nxt;
  logic              ol_r, ol_nxt;
  logic              ob_r, ob_nxt;

  logic              accept;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  count_dec;
  logic              load;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign count_inc = count_r + CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);
  assign load      = !ov_r || out_ready;

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    neg_nxt          = neg_r;
    bad_nxt          = bad_r;
    radix_nxt        = radix_r;
    store_we         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = radix_r;
    ov_nxt           = ov_r && !out_ready;
    oc_nxt           = oc_r;
    ol_nxt           = ol_r;
    ob_nxt           = ob_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = in_number[VALUE_BITS-1];
          radix_nxt = radix;
          count_nxt = '0;
          if (radix_ok(radix)) begin
            bad_nxt          = 1'b0;
            div_req.start    = 1'b1;
            div_req.divisor  = radix;
            div_req.dividend = in_number[VALUE_BITS-1] ? (~in_number + VALUE_BITS'(1))
                                                       : in_number;
            state_nxt        = ST_DIV;
          end else begin
            bad_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          store_we  = 1'b1;
          count_nxt = count_inc;
          // Keep dividing until the quotient runs out or the store is full.
          if (div_rsp.quotient != '0 && count_inc < CNT_W'(VALUE_BITS)) begin
            div_req.start = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          ov_nxt = 1'b1;
          if (bad_r) begin
            oc_nxt    = CHAR_NONE;
            ol_nxt    = 1'b1;
            ob_nxt    = 1'b1;
            bad_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else if (neg_r) begin
            oc_nxt  = CHAR_MINUS;
            ol_nxt  = 1'b0;
            ob_nxt  = 1'b0;
            neg_nxt = 1'b0;
          end else begin
            oc_nxt    = glyph(digit_store[count_dec[IDX_W-1:0]]);
            ol_nxt    = (count_r == CNT_W'(1));
            ob_nxt    = 1'b0;
            count_nxt = count_dec;
            if (count_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r <= radix_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
    ob_r    <= ob_nxt;
    if (store_we) begin
      digit_store[count_r[IDX_W-1:0]] <= div_rsp.remainder;
    end
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;
  assign out_bad   = ob_r;

endmodule

// ----- sv/integer_to_radix_string_unit.sv -----
// Signed integer to ASCII text in a programmable base.
// Input stream: one 32-bit two's complement value per transfer on in_tdata.
// Output stream: one character per transfer on out_tdata; out_tlast marks the
// final character of a value's text and out_tuser flags a bad radix. A
// negative value starts with '-', then the digits follow from most
// significant, written 0-9 then a-z.
// The base is the radix register at APB address 0 (reset value 10). A radix
// outside 2..36 gives a single transfer with character 0, tlast and tuser.
// Each digit costs one pass of the shared restoring divider, which produces
// 32 quotient bits; the remainder is then stored and the next pass started.
// The first character of a value follows once all its digits are found,
// then one character per cycle while the receiver is ready; the worst case is
// the most negative value in base 2, 32 digits plus the sign. A bad radix
// answers without a divider pass.
// in_tready stays low from acceptance until the last character is loaded
// into the output register; the next value may be taken while that last
// character still waits. When out_tready is low the output register holds
// its character and the sequencer waits.
// Reset is synchronous: the stream channels go idle and radix returns to 10.
module integer_to_radix_string_unit
  import i2rs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,    // [31:0] number
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CHAR_W-1:0]     out_tdata,   // [7:0] character
  output logic                  out_tlast,
  output logic                  out_tuser,   // [0] bad_radix
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic               cfg_wr;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_wr && cfg_paddr[CFG_AW-1] == REG_RADIX) begin
      radix_nxt = cfg_pwdata[RADIX_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1] == REG_RADIX) begin
      cfg_prdata = CFG_DW'(radix_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  i2rs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_number (in_tdata[VALUE_BITS-1:0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_bad   (out_tuser),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  i2rs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

`ifndef ASSERT_OFF
  // A bad-radix answer is always a lone zero character.
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == CHAR_NONE && out_tlast)
    else $error("bad radix result is not a lone zero character");

  // A value with a good radix keeps the input closed while digits are found.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && radix_r >= RADIX_MIN && radix_r <= RADIX_MAX
    |=> !in_tready)
    else $error("input accepted again while dividing");

  // A register write lands in the radix register on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_paddr[CFG_AW-1] == REG_RADIX
    |=> radix_r == $past(cfg_pwdata[RADIX_W-1:0]))
    else $error("radix register write lost");

  // The divider never reports a finished pass while the sequencer sits idle.
  a_div_idle_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> !div_rsp.done || !$past(in_tready, 2))
    else $error("divider finished while the sequencer was idle");
`endif

endmodule

// ----- verif/radix_text_checker.sv -----
`timescale 1ns / 100ps
module radix_text_checker
  import i2rs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,    // [31:0] number
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [CHAR_W-1:0]     out_tdata,   // [7:0] character
  input  logic                  out_tlast,
  input  logic                  out_tuser,   // [0] bad_radix
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  input  logic [CFG_DW-1:0]     cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    chars_pending
);

  localparam logic [CFG_AW-1:0] RADIX_ADDR = CFG_AW'(REG_RADIX) << 2;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              bad;
  } text_char_t;

  text_char_t         expected_chars[$];
  logic [RADIX_W-1:0] base_q;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    if (d < DIG_W'(10)) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_ALPHA + CHAR_W'(d - DIG_W'(10));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Appends one character to the tail of the expected run.
  task automatic add_expected(input logic [CHAR_W-1:0] code, input logic last,
                              input logic bad);
    text_char_t c;
    c.code = code;
    c.last = last;
    c.bad  = bad;
    expected_chars.insert(expected_chars.size(), c);
  endtask

  // Builds the characters one value turns into under the current base.
  task automatic expect_text(input logic [VALUE_BITS-1:0] number);
    logic [VALUE_BITS-1:0] mag;
    logic [DIG_W-1:0]      digits[VALUE_BITS];
    int                    n;
    if (base_q < RADIX_MIN || base_q > RADIX_MAX) begin
      add_expected(CHAR_NONE, 1'b1, 1'b1);
      return;
    end
    // Negating as an unsigned quantity keeps the most negative value exact.
    mag = number[VALUE_BITS-1] ? -number : number;
    n = 0;
    do begin
      digits[n] = DIG_W'(mag % VALUE_BITS'(base_q));
      mag = mag / VALUE_BITS'(base_q);
      n++;
    end while (mag != '0);
    if (number[VALUE_BITS-1]) begin
      add_expected(CHAR_MINUS, 1'b0, 1'b0);
    end
    for (int k = n - 1; k >= 0; k--) begin
      add_expected(digit_char(digits[k]), (k == 0), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      base_q = RADIX_RESET;
      expected_chars.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == RADIX_ADDR) begin
        if (cfg_pwrite) begin
          base_q = cfg_pwdata[RADIX_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(base_q)) begin
          report_mismatch($sformatf("radix read back %0h, expected %0h", cfg_prdata, base_q));
        end
      end
      if (in_tvalid && in_tready) begin
        expect_text(in_tdata[VALUE_BITS-1:0]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %02h", out_tdata));
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.code) begin
            report_mismatch($sformatf("character %02h, expected %02h", out_tdata, want.code));
          end
          if (out_tlast !== want.last) begin
            report_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.last));
          end
          if (out_tuser !== want.bad) begin
            report_mismatch($sformatf("bad radix flag %b, expected %b", out_tuser, want.bad));
          end
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

// ----- verif/integer_to_radix_string_unit_tb.sv -----
`timescale 1ns / 100ps
module integer_to_radix_string_unit_tb;
  import i2rs_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_CYCLES  = 1100;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_PCT      = 13;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 20;

  localparam logic [CFG_AW-1:0]     RADIX_ADDR  = CFG_AW'(REG_RADIX) << 2;
  localparam logic [CFG_AW-1:0]     UNUSED_ADDR = RADIX_ADDR + CFG_AW'(4);
  localparam logic [VALUE_BITS-1:0] MOST_NEG    = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MOST_POS    = ~MOST_NEG;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CHAR_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int   mismatches;
  int   chars_pending;
  int   cycle_count = 0;
  logic quiet;
  logic long_hold;

  integer_to_radix_string_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  radix_text_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic cfg_access(input logic is_write, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_radix(input logic [CFG_DW-1:0] data);
    cfg_access(1'b1, RADIX_ADDR, data);
    cfg_access(1'b0, RADIX_ADDR, '0);
  endtask

  task automatic send_number(input logic [VALUE_BITS-1:0] number);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(number);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every character of the sent values is back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_number();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 19))
      0: v = MOST_NEG;
      1: v = MOST_POS;
      2: v = '0;
      3: v = '1;
      4, 5, 6: begin
        v = VALUE_BITS'($urandom_range(0, 100));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      7, 8, 9: v = VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
      default: v = VALUE_BITS'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    case ($urandom_range(0, 9))
      0: return RADIX_MIN;
      1: return RADIX_MAX;
      2: begin
        if ($urandom_range(0, 1) != 0) return RADIX_W'($urandom_range(0, 1));
        return RADIX_W'($urandom_range(37, 63));
      end
      default: return RADIX_W'($urandom_range(2, 36));
    endcase
  endfunction

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quiet       = 1'b0;
    long_hold   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Base 10 straight out of reset.
    cfg_access(1'b0, RADIX_ADDR, '0);
    send_number('0);
    send_number(VALUE_BITS'(1));
    send_number('1);
    send_number(MOST_POS);
    send_number(MOST_NEG);
    send_number(VALUE_BITS'(10));
    send_number(VALUE_BITS'(-9));
    wait_idle();

    // Base 2: the most negative value gives the longest run.
    set_radix(CFG_DW'(RADIX_MIN));
    send_number(MOST_NEG);
    send_number('1);
    send_number(MOST_POS);
    send_number(VALUE_BITS'(5));
    wait_idle();

    set_radix(CFG_DW'(RADIX_MAX));
    send_number(VALUE_BITS'(35));
    send_number(VALUE_BITS'(36));
    send_number(MOST_NEG);
    wait_idle();

    // Upper write data bits are not part of the register.
    set_radix({26'h2a5a5a5, 6'd16});
    send_number(VALUE_BITS'(32'hdeadbeef));
    send_number('0);
    wait_idle();

    // A write to an unmapped word leaves the base alone.
    cfg_access(1'b1, UNUSED_ADDR, CFG_DW'(3));
    cfg_access(1'b0, RADIX_ADDR, '0);
    send_number(VALUE_BITS'(255));
    wait_idle();

    // Bases outside the valid range answer with one flagged transfer.
    set_radix(CFG_DW'(0));
    send_number(VALUE_BITS'(12));
    wait_idle();
    set_radix(CFG_DW'(1));
    send_number('1);
    wait_idle();
    set_radix(CFG_DW'(37));
    send_number('0);
    wait_idle();
    set_radix(CFG_DW'(63));
    send_number(MOST_NEG);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_radix(CFG_DW'(random_radix()));
      quiet = (p == 3);
      if (p == 5) long_hold = 1'b1;
      repeat (PHASE_ITEMS) send_number(random_number());
      wait_idle();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/i2rs_pkg.sv
sv/i2rs_divider.sv
sv/i2rs_seq.sv
sv/integer_to_radix_string_unit.sv
verif/radix_text_checker.sv
verif/integer_to_radix_string_unit_tb.sv
